### rtl/vrq_pkg.sv
package vrq_pkg;

  localparam int unsigned RING_BYTES  = 1024;
  localparam int unsigned MAX_RECORD  = 64;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned PTR_W  = $clog2(RING_BYTES);
  localparam int unsigned FREE_W = $clog2(RING_BYTES + 1);
  localparam int unsigned REC_W  = PTR_W;
  localparam int unsigned LEN_W  = 7;
  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] CMD_OPEN  = 3'd0;
  localparam logic [2:0] CMD_PUSH  = 3'd1;
  localparam logic [2:0] CMD_POP   = 3'd2;
  localparam logic [2:0] CMD_PEEK  = 3'd3;
  localparam logic [2:0] CMD_CLEAR = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_ROOM = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_SEQ     = 2'd3;

  typedef enum logic [2:0] {
    OP_OPEN,
    OP_PUSH,
    OP_POP,
    OP_PEEK,
    OP_CLEAR,
    OP_NONE
  } op_e;

  typedef struct packed {
    logic [2:0]       cmd;
    logic [7:0]       data_byte;
    logic [LEN_W-1:0] rec_len;
    logic [LEN_W-1:0] read_limit;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic       byte_valid;
    logic [7:0] out_byte;
    logic       last;
    logic       queue_empty;
  } out_t;

  typedef struct packed {
    op_e              op;
    logic [7:0]       data_byte;
    logic [LEN_W-1:0] rec_len;
    logic [LEN_W-1:0] read_limit;
  } op_t;

  typedef struct packed {
    logic             we;
    logic [PTR_W-1:0] waddr;
    logic [7:0]       wdata;
    logic             re;
    logic [PTR_W-1:0] raddr;
  } ram_req_t;

endpackage

### rtl/vrq_ram.sv
module vrq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/vrq_front.sv
module vrq_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  vrq_pkg::in_t    in_data_i,
  output logic            op_valid_o,
  input  logic            op_ready_i,
  output vrq_pkg::op_t    op_o
);

  vrq_pkg::op_t                  entry_q [vrq_pkg::QUEUE_DEPTH];
  logic [vrq_pkg::QPTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [vrq_pkg::QPTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [vrq_pkg::QCNT_W-1:0]    cnt_q, cnt_d;
  vrq_pkg::op_t                  op_new;
  logic                          push, pop;

  always_comb begin
    op_new.data_byte  = in_data_i.data_byte;
    op_new.rec_len    = in_data_i.rec_len;
    op_new.read_limit = in_data_i.read_limit;
    unique case (in_data_i.cmd)
      vrq_pkg::CMD_OPEN:  op_new.op = vrq_pkg::OP_OPEN;
      vrq_pkg::CMD_PUSH:  op_new.op = vrq_pkg::OP_PUSH;
      vrq_pkg::CMD_POP:   op_new.op = vrq_pkg::OP_POP;
      vrq_pkg::CMD_PEEK:  op_new.op = vrq_pkg::OP_PEEK;
      vrq_pkg::CMD_CLEAR: op_new.op = vrq_pkg::OP_CLEAR;
      default:            op_new.op = vrq_pkg::OP_NONE;
    endcase
  end

  assign in_ready_o = (cnt_q != vrq_pkg::QCNT_W'(vrq_pkg::QUEUE_DEPTH));
  assign op_valid_o = (cnt_q != '0);
  assign op_o       = entry_q[rd_ptr_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = op_valid_o && op_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == vrq_pkg::QPTR_W'(vrq_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == vrq_pkg::QPTR_W'(vrq_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= op_new;
    end
  end

endmodule

### rtl/vrq_back.sv
module vrq_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                op_valid_i,
  output logic                op_ready_o,
  input  vrq_pkg::op_t        op_i,
  output vrq_pkg::ram_req_t   ram_req_o,
  input  logic [7:0]          ram_rdata_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output vrq_pkg::out_t       out_data_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_HDR  = 3'b010,
    S_EMIT = 3'b100
  } state_e;

  state_e                           state_q, state_d;
  logic [vrq_pkg::PTR_W-1:0]        head_q, head_d;
  logic [vrq_pkg::PTR_W-1:0]        tail_q, tail_d;
  logic [vrq_pkg::PTR_W-1:0]        pos_q, pos_d;
  logic [vrq_pkg::FREE_W-1:0]       free_q, free_d;
  logic [vrq_pkg::LEN_W-1:0]        open_q, open_d;
  logic [vrq_pkg::REC_W-1:0]        recs_q, recs_d;
  logic [vrq_pkg::LEN_W-1:0]        cnt_q, cnt_d;
  logic [vrq_pkg::LEN_W-1:0]        limit_q, limit_d;
  logic                             remove_q, remove_d;
  logic                             out_valid_q, out_valid_d;
  vrq_pkg::out_t                    out_q, out_d;

  logic                             out_free;
  logic                             emit;
  logic [1:0]                       emit_status;
  logic                             emit_byte_valid;
  logic [7:0]                       emit_byte;
  logic                             emit_last;
  logic [vrq_pkg::FREE_W-1:0]       need;
  logic [7:0]                       n_min;
  logic [vrq_pkg::LEN_W-1:0]        n_cnt;
  logic [vrq_pkg::PTR_W+1:0]        skip_sum;
  logic [vrq_pkg::FREE_W:0]         free_sum;

  function automatic logic [vrq_pkg::PTR_W-1:0] advance(input logic [vrq_pkg::PTR_W-1:0] p);
    return (p == vrq_pkg::PTR_W'(vrq_pkg::RING_BYTES - 1)) ? '0 : p + 1'b1;
  endfunction

  assign out_free   = !out_valid_q || out_ready_i;
  assign op_ready_o = (state_q == S_IDLE) && out_free;
  assign need       = vrq_pkg::FREE_W'(op_i.rec_len) + 1'b1;

  always_comb begin
    n_min = (ram_rdata_i < {1'b0, limit_q}) ? ram_rdata_i : {1'b0, limit_q};
    n_cnt = (n_min > 8'(vrq_pkg::MAX_RECORD)) ? vrq_pkg::LEN_W'(vrq_pkg::MAX_RECORD)
                                              : n_min[vrq_pkg::LEN_W-1:0];
    skip_sum = (vrq_pkg::PTR_W + 2)'(head_q) + (vrq_pkg::PTR_W + 2)'(ram_rdata_i) + 1'b1;
    if (skip_sum >= (vrq_pkg::PTR_W + 2)'(vrq_pkg::RING_BYTES)) begin
      skip_sum = skip_sum - (vrq_pkg::PTR_W + 2)'(vrq_pkg::RING_BYTES);
    end
    free_sum = (vrq_pkg::FREE_W + 1)'(free_q) + (vrq_pkg::FREE_W + 1)'(ram_rdata_i) + 1'b1;
    if (free_sum > (vrq_pkg::FREE_W + 1)'(vrq_pkg::RING_BYTES)) begin
      free_sum = (vrq_pkg::FREE_W + 1)'(vrq_pkg::RING_BYTES);
    end
  end

  always_comb begin
    state_d         = state_q;
    head_d          = head_q;
    tail_d          = tail_q;
    pos_d           = pos_q;
    free_d          = free_q;
    open_d          = open_q;
    recs_d          = recs_q;
    cnt_d           = cnt_q;
    limit_d         = limit_q;
    remove_d        = remove_q;
    ram_req_o       = '0;
    emit            = 1'b0;
    emit_status     = vrq_pkg::ST_OK;
    emit_byte_valid = 1'b0;
    emit_byte       = '0;
    emit_last       = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (op_valid_i && out_free) begin
          unique case (op_i.op)
            vrq_pkg::OP_OPEN: begin
              emit = 1'b1;
              if (open_q != '0) begin
                emit_status = vrq_pkg::ST_SEQ;
              end else if (op_i.rec_len == '0 ||
                           op_i.rec_len > vrq_pkg::LEN_W'(vrq_pkg::MAX_RECORD) ||
                           free_q < need) begin
                emit_status = vrq_pkg::ST_NO_ROOM;
              end else begin
                free_d          = free_q - need;
                ram_req_o.we    = 1'b1;
                ram_req_o.waddr = tail_q;
                ram_req_o.wdata = 8'(op_i.rec_len);
                tail_d          = advance(tail_q);
                open_d          = op_i.rec_len;
              end
            end
            vrq_pkg::OP_PUSH: begin
              emit = 1'b1;
              if (open_q == '0) begin
                emit_status = vrq_pkg::ST_SEQ;
              end else begin
                ram_req_o.we    = 1'b1;
                ram_req_o.waddr = tail_q;
                ram_req_o.wdata = op_i.data_byte;
                tail_d          = advance(tail_q);
                open_d          = open_q - 1'b1;
                if (open_q == vrq_pkg::LEN_W'(1)) begin
                  recs_d = recs_q + 1'b1;
                end
              end
            end
            vrq_pkg::OP_POP, vrq_pkg::OP_PEEK: begin
              if (recs_q == '0) begin
                emit        = 1'b1;
                emit_status = (open_q != '0) ? vrq_pkg::ST_SEQ : vrq_pkg::ST_EMPTY;
              end else begin
                ram_req_o.re    = 1'b1;
                ram_req_o.raddr = head_q;
                limit_d         = op_i.read_limit;
                remove_d        = (op_i.op == vrq_pkg::OP_POP);
                state_d         = S_HDR;
              end
            end
            vrq_pkg::OP_CLEAR: begin
              emit   = 1'b1;
              tail_d = head_q;
              free_d = vrq_pkg::FREE_W'(vrq_pkg::RING_BYTES);
              open_d = '0;
              recs_d = '0;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      S_HDR: begin
        if (out_free) begin
          if (remove_q) begin
            head_d = skip_sum[vrq_pkg::PTR_W-1:0];
            free_d = free_sum[vrq_pkg::FREE_W-1:0];
            recs_d = recs_q - 1'b1;
          end
          if (n_cnt == '0) begin
            emit    = 1'b1;
            state_d = S_IDLE;
          end else begin
            ram_req_o.re    = 1'b1;
            ram_req_o.raddr = advance(head_q);
            pos_d           = advance(head_q);
            cnt_d           = n_cnt;
            state_d         = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          emit            = 1'b1;
          emit_byte_valid = 1'b1;
          emit_byte       = ram_rdata_i;
          emit_last       = (cnt_q == vrq_pkg::LEN_W'(1));
          if (cnt_q == vrq_pkg::LEN_W'(1)) begin
            state_d = S_IDLE;
          end else begin
            ram_req_o.re    = 1'b1;
            ram_req_o.raddr = advance(pos_q);
            pos_d           = advance(pos_q);
            cnt_d           = cnt_q - 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (emit) begin
      out_valid_d       = 1'b1;
      out_d.status      = emit_status;
      out_d.byte_valid  = emit_byte_valid;
      out_d.out_byte    = emit_byte;
      out_d.last        = emit_last;
      out_d.queue_empty = (free_d == vrq_pkg::FREE_W'(vrq_pkg::RING_BYTES));
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      free_q      <= vrq_pkg::FREE_W'(vrq_pkg::RING_BYTES);
      open_q      <= '0;
      recs_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      free_q      <= free_d;
      open_q      <= open_d;
      recs_q      <= recs_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    cnt_q    <= cnt_d;
    limit_q  <= limit_d;
    remove_q <= remove_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### rtl/variable_record_ring_queue.sv
// A queue of variable-length byte records kept in a 1024-byte ring memory, each record stored
// behind a one-byte length header. Commands pass through a two-beat queue into an executor;
// open, push, clear and unknown codes, and pop or peek that find no complete record, produce
// one result beat each. Any other pop or peek first reads the header from the ring memory and
// then delivers one byte per cycle while the output is not stalled, limited by the single
// read port of that memory; the executor takes no new command until it has delivered the
// last byte, or a byteless result when the read limit lets no byte through. Output
// back-pressure stalls the executor, while the command queue keeps accepting beats until it
// holds two. The ring memory needs no clearing after reset, since only bytes already written
// are ever read.
module variable_record_ring_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  vrq_pkg::in_t    in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output vrq_pkg::out_t   out_data_o
);

  logic              op_valid;
  logic              op_ready;
  vrq_pkg::op_t      op;
  vrq_pkg::ram_req_t ram_req;
  logic [7:0]        ram_rdata;

  vrq_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .op_valid_o (op_valid),
    .op_ready_i (op_ready),
    .op_o       (op)
  );

  vrq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (op_valid),
    .op_ready_o  (op_ready),
    .op_i        (op),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  vrq_ram #(
    .WIDTH (8),
    .DEPTH (vrq_pkg::RING_BYTES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

endmodule

### rtl/vrq_checker.sv
module vrq_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input vrq_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input vrq_pkg::out_t out_data_o
);

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("Command beat changed while stalled.");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("Result beat changed while stalled.");

  a_plain_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.byte_valid |-> out_data_o.last)
    else $error("A result without a byte is not the final beat.");

  a_plain_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.byte_valid |-> out_data_o.out_byte == 8'd0)
    else $error("A result without a byte carries a nonzero byte.");

  a_byte_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.byte_valid |-> out_data_o.status == vrq_pkg::ST_OK)
    else $error("A delivered byte carries an error status.");

endmodule

bind variable_record_ring_queue vrq_checker u_vrq_checker (.*);
